/* design/cotc_pkg.sv */
package cotc_pkg;

  // Field widths of the circle words.
  localparam int COORD_BITS  = 10;
  localparam int RADIUS_BITS = 8;
  localparam int MODE_BITS   = 2;
  localparam int HIT_BITS    = 4;
  localparam int COUNT_BITS  = 5;

  // Default number of table entries.
  localparam int TABLE_DEPTH = 16;

  // Squared terms: dx*dx + dy*dy needs one bit over a square, (r0 + r1)^2 two radius bits more.
  localparam int DIST_SQ_BITS = 2 * COORD_BITS + 1;
  localparam int RAD_SQ_BITS  = 2 * (RADIUS_BITS + 1);
  localparam int SQ_BITS      = (DIST_SQ_BITS > RAD_SQ_BITS) ? DIST_SQ_BITS : RAD_SQ_BITS;

  // Operation codes carried in the mode field. The unused code acts as a query.
  localparam logic [MODE_BITS-1:0] MODE_QUERY  = 2'd0;
  localparam logic [MODE_BITS-1:0] MODE_APPEND = 2'd1;
  localparam logic [MODE_BITS-1:0] MODE_CLEAR  = 2'd2;

  // Input word.
  typedef struct packed {
    logic [MODE_BITS-1:0]   mode;
    logic [COORD_BITS-1:0]  center_x;
    logic [COORD_BITS-1:0]  center_y;
    logic [RADIUS_BITS-1:0] radius;
  } in_word_t;

  // Result word.
  typedef struct packed {
    logic                  collided;
    logic [HIT_BITS-1:0]   hit_index;
    logic                  appended;
    logic                  table_full;
    logic [COUNT_BITS-1:0] entry_count;
  } out_word_t;

  // One stored table entry.
  typedef struct packed {
    logic [COORD_BITS-1:0]  x;
    logic [COORD_BITS-1:0]  y;
    logic [RADIUS_BITS-1:0] r;
  } circle_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load_probe;
    logic issue;
    logic finish;
  } dp_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic scan_done;
    logic pipe_idle;
  } dp_status_t;

endpackage

/* design/cotc_ctrl.sv */
module cotc_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output cotc_pkg::dp_cmd_t   cmd_o,
  input  cotc_pkg::dp_status_t status_i
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DRAIN,
    ST_FINISH
  } state_e;

  state_e state_q;
  logic   out_valid_q;

  // Commands decoded from the current state.
  always_comb begin
    cmd_o.load_probe = (state_q == ST_IDLE) && in_valid_i;
    cmd_o.issue      = (state_q == ST_SCAN) && !status_i.scan_done;
    cmd_o.finish     = (state_q == ST_FINISH) && (!out_valid_q || !out_stall_i);
  end

  assign in_stall_o  = (state_q != ST_IDLE);
  assign out_valid_o = out_valid_q;

  // Sequencer and output valid flag.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      unique case (state_q)
        ST_IDLE: begin
          if (in_valid_i) begin
            state_q <= ST_SCAN;
          end
        end
        ST_SCAN: begin
          if (status_i.scan_done) begin
            state_q <= ST_DRAIN;
          end
        end
        ST_DRAIN: begin
          if (status_i.pipe_idle) begin
            state_q <= ST_FINISH;
          end
        end
        ST_FINISH: begin
          if (cmd_o.finish) begin
            state_q <= ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase

      // A new result replaces the old one only once that one is gone.
      if (cmd_o.finish) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // The compare pipeline is empty whenever a new word can enter.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_IDLE) |-> status_i.pipe_idle)
    else $error("compare pipeline busy while idle");

  // Accepting a word always starts a scan.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> (state_q == ST_SCAN))
    else $error("accepted word did not start a scan");

  // Once the scan has finished issuing, it stays finished while draining.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DRAIN) |-> status_i.scan_done)
    else $error("scan restarted during drain");

endmodule

/* design/cotc_dp.sv */
module cotc_dp #(
  parameter int TABLE_DEPTH = cotc_pkg::TABLE_DEPTH
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  cotc_pkg::in_word_t   in_data_i,
  input  cotc_pkg::dp_cmd_t    cmd_i,
  output cotc_pkg::dp_status_t status_o,
  output cotc_pkg::out_word_t  out_data_o
);

  localparam int IdxW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CntW = $clog2(TABLE_DEPTH + 1);
  localparam int CW   = cotc_pkg::COORD_BITS;
  localparam int RW   = cotc_pkg::RADIUS_BITS;
  localparam int SQW  = cotc_pkg::SQ_BITS;

  // Circle table, read one entry a cycle during the scan.
  cotc_pkg::circle_t mem_q [TABLE_DEPTH];

  cotc_pkg::in_word_t  probe_q;
  cotc_pkg::out_word_t res_q;

  logic [CntW-1:0] count_q;
  logic [CntW-1:0] count_d;
  logic [CntW-1:0] rd_addr_q;

  // Pipeline: stage 1 table read, stage 2 differences, stage 3 squares.
  logic              v1_q, v2_q, v3_q;
  logic [IdxW-1:0]   idx1_q, idx2_q, idx3_q;
  cotc_pkg::circle_t ent_q;
  logic [CW-1:0]     dx_q, dy_q;
  logic [RW:0]       rs_q;
  logic [2*CW-1:0]   dx2_q, dy2_q;
  logic [2*RW+1:0]   rs2_q;

  logic            hit_q;
  logic [IdxW-1:0] hit_idx_q;

  logic [CW-1:0]   dx_d, dy_d;
  logic [RW:0]     rs_d;
  logic [SQW-1:0]  dist_sq;
  logic [SQW-1:0]  rad_sq;
  logic            overlap;

  logic            is_clear;
  logic            want_app;
  logic            room;
  logic            appended_w;
  logic            full_w;
  logic [31:0]     hit_wide;
  logic [31:0]     count_wide;

  // Absolute center differences and radius sum.
  always_comb begin
    dx_d = (probe_q.center_x >= ent_q.x) ? (probe_q.center_x - ent_q.x)
                                         : (ent_q.x - probe_q.center_x);
    dy_d = (probe_q.center_y >= ent_q.y) ? (probe_q.center_y - ent_q.y)
                                         : (ent_q.y - probe_q.center_y);
    rs_d = {1'b0, probe_q.radius} + {1'b0, ent_q.r};
  end

  // Strict overlap test on the squared values.
  always_comb begin
    dist_sq = SQW'({1'b0, dx2_q} + {1'b0, dy2_q});
    rad_sq  = SQW'(rs2_q);
    overlap = dist_sq < rad_sq;
  end

  // Append and result decisions for the finishing word.
  always_comb begin
    is_clear   = (probe_q.mode == cotc_pkg::MODE_CLEAR);
    want_app   = (probe_q.mode == cotc_pkg::MODE_APPEND) && !hit_q;
    room       = count_q < CntW'(TABLE_DEPTH);
    appended_w = want_app && room;
    full_w     = want_app && !room;
    if (is_clear) begin
      count_d = '0;
    end else if (appended_w) begin
      count_d = count_q + 1'b1;
    end else begin
      count_d = count_q;
    end
    hit_wide   = 32'(hit_idx_q);
    count_wide = 32'(count_d);
  end

  assign status_o.scan_done = is_clear || (rd_addr_q == count_q);
  assign status_o.pipe_idle = !(v1_q || v2_q || v3_q);
  assign out_data_o         = res_q;

  // Control registers: fill count, scan address, stage valids, first hit.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q   <= '0;
      rd_addr_q <= '0;
      v1_q      <= 1'b0;
      v2_q      <= 1'b0;
      v3_q      <= 1'b0;
      hit_q     <= 1'b0;
      hit_idx_q <= '0;
    end else begin
      v1_q <= cmd_i.issue;
      v2_q <= v1_q;
      v3_q <= v2_q;
      if (cmd_i.load_probe) begin
        rd_addr_q <= '0;
        hit_q     <= 1'b0;
        hit_idx_q <= '0;
      end else begin
        if (cmd_i.issue) begin
          rd_addr_q <= rd_addr_q + 1'b1;
        end
        // Only the first overlapping entry is kept.
        if (v3_q && !hit_q && overlap) begin
          hit_q     <= 1'b1;
          hit_idx_q <= idx3_q;
        end
      end
      if (cmd_i.finish) begin
        count_q <= count_d;
      end
    end
  end

  // Payload registers and the table itself.
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_probe) begin
      probe_q <= in_data_i;
    end
    ent_q  <= mem_q[rd_addr_q[IdxW-1:0]];
    idx1_q <= rd_addr_q[IdxW-1:0];
    idx2_q <= idx1_q;
    idx3_q <= idx2_q;
    dx_q   <= dx_d;
    dy_q   <= dy_d;
    rs_q   <= rs_d;
    dx2_q  <= dx_q * dx_q;
    dy2_q  <= dy_q * dy_q;
    rs2_q  <= rs_q * rs_q;
    if (cmd_i.finish) begin
      if (appended_w) begin
        mem_q[count_q[IdxW-1:0]] <= '{x: probe_q.center_x,
                                      y: probe_q.center_y,
                                      r: probe_q.radius};
      end
      res_q.collided    <= hit_q;
      res_q.hit_index   <= hit_wide[cotc_pkg::HIT_BITS-1:0];
      res_q.appended    <= appended_w;
      res_q.table_full  <= full_w;
      res_q.entry_count <= count_wide[cotc_pkg::COUNT_BITS-1:0];
    end
  end

  // The fill count never passes the table size.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntW'(TABLE_DEPTH))
    else $error("fill count beyond table size");

  // An append grows the table by exactly one entry.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.finish && appended_w) |=> (count_q == $past(count_q) + 1'b1))
    else $error("append did not advance the fill count");

  // A word that collided is neither stored nor refused as full.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.finish && hit_q) |-> (!appended_w && !full_w))
    else $error("colliding word treated as free");

endmodule

/* design/circle_overlap_table_check.sv */
// Circle overlap table check.
// The block keeps a table of placed circles and tests each input word (a circle
// with a mode) against the stored entries in index order, reporting the first
// entry whose squared center distance is strictly below the squared radius sum.
// Mode query only reports; mode append also stores a free circle, or flags
// table_full when no entry is left; mode clear empties the table.
// Input channel: in_valid_i, in_stall_o, in_data_i. A word is taken when valid
// is high and stall is low. Output channel: out_valid_o, out_stall_i, out_data_o,
// with one result word per input word.
// Sequence: after acceptance the block scans the stored entries, drains the
// compare pipeline and then loads the result; with an empty table or a clear
// no entry is read. One word is worked on at a time; the next is taken in
// the cycle after the result is loaded. The scan
// reads one table entry a cycle through a three stage compare pipeline.
// Reset empties the table; entry contents are not cleared.
// A stalled result is held in the output register; a finished word waits in
// the block until that register frees, and no new word is taken meanwhile.
module circle_overlap_table_check #(
  parameter int TABLE_DEPTH = cotc_pkg::TABLE_DEPTH
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  cotc_pkg::in_word_t  in_data_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output cotc_pkg::out_word_t out_data_o
);

  cotc_pkg::dp_cmd_t    cmd;
  cotc_pkg::dp_status_t status;

  // Sequencer.
  cotc_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .cmd_o       (cmd),
    .status_i    (status)
  );

  // Table, compare pipeline and result register.
  cotc_dp #(
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_data_i  (in_data_i),
    .cmd_i      (cmd),
    .status_o   (status),
    .out_data_o (out_data_o)
  );

endmodule

/* test/circle_overlap_table_check_test.sv */
module circle_overlap_table_check_test;
  timeunit 1ns;
  timeprecision 1ps;

  import cotc_pkg::*;

  // The spare mode code is not named in the package; it behaves as a query.
  localparam logic [MODE_BITS-1:0] MODE_SPARE = 2'd3;

  localparam int TOTAL_WORDS = 975;
  localparam int DRAIN_CYCLES = 40;
  localparam int CYCLE_LIMIT = 400000;
  localparam int COORD_MAX = (1 << COORD_BITS) - 1;

  // Tracks the circle table and queues the verdict that each probe must produce.
  class circle_table_tracker;
    circle_t   placed[TABLE_DEPTH];
    int        placed_count = 0;
    out_word_t due_verdicts[$];
    int        mismatches = 0;

    // Strict integer overlap test: squared distance below squared radius sum.
    function bit circles_overlap(circle_t a, circle_t b);
      int dx;
      int dy;
      int rs;
      dx = int'(a.x) - int'(b.x);
      dy = int'(a.y) - int'(b.y);
      rs = int'(a.r) + int'(b.r);
      return (dx * dx + dy * dy) < (rs * rs);
    endfunction

    // Apply one accepted word to the table copy and queue its verdict.
    function void take_probe(in_word_t w);
      circle_t   probe;
      out_word_t verdict;
      probe.x = w.center_x;
      probe.y = w.center_y;
      probe.r = w.radius;
      verdict = '0;
      if (w.mode == MODE_CLEAR) begin
        placed_count = 0;
      end else begin
        for (int i = 0; i < placed_count; i++) begin
          if (circles_overlap(probe, placed[i])) begin
            verdict.collided = 1'b1;
            verdict.hit_index = i[HIT_BITS-1:0];
            break;
          end
        end
        if (w.mode == MODE_APPEND && !verdict.collided) begin
          if (placed_count < TABLE_DEPTH) begin
            placed[placed_count] = probe;
            placed_count++;
            verdict.appended = 1'b1;
          end else begin
            verdict.table_full = 1'b1;
          end
        end
      end
      verdict.entry_count = placed_count[COUNT_BITS-1:0];
      due_verdicts.push_back(verdict);
    endfunction

    function void compare_field(string field, int want, int got);
      if (want != got) begin
        $display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
        mismatches++;
      end
    endfunction

    // Compare a delivered result word against the oldest queued verdict.
    function void check_verdict(out_word_t got);
      out_word_t want;
      if (due_verdicts.size() == 0) begin
        $display("%0t ns: unexpected result word, expected none, actual %p", $time, got);
        mismatches++;
        return;
      end
      want = due_verdicts.pop_front();
      compare_field("collided", int'(want.collided), int'(got.collided));
      compare_field("hit_index", int'(want.hit_index), int'(got.hit_index));
      compare_field("appended", int'(want.appended), int'(got.appended));
      compare_field("table_full", int'(want.table_full), int'(got.table_full));
      compare_field("entry_count", int'(want.entry_count), int'(got.entry_count));
    endfunction
  endclass

  logic      clk_i = 1'b0;
  logic      rst_ni = 1'b0;
  logic      in_valid_i = 1'b0;
  logic      in_stall_o;
  in_word_t  in_data_i = '0;
  logic      out_valid_o;
  logic      out_stall_i = 1'b0;
  out_word_t out_data_o;

  circle_table_tracker tracker = new;

  int idle_pct = 0;
  int stall_pct = 0;
  int words_sent = 0;
  int cycle_count = 0;

  circle_overlap_table_check u_top (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_data_o (out_data_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Guard against a hung run.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // The receiver stalls at random with the rate of the current phase.
  always @(posedge clk_i) begin
    out_stall_i <= ($urandom_range(0, 99) < stall_pct);
  end

  // Outputs are stable at the falling edge, so a word seen there is taken at the next rise.
  always @(negedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      tracker.check_verdict(out_data_o);
    end
  end

  function automatic in_word_t circle_word(logic [MODE_BITS-1:0] mode, int x, int y, int r);
    in_word_t w;
    w.mode = mode;
    w.center_x = x[COORD_BITS-1:0];
    w.center_y = y[COORD_BITS-1:0];
    w.radius = r[RADIUS_BITS-1:0];
    return w;
  endfunction

  function automatic int clamp_coord(int c);
    return (c < 0) ? 0 : (c > COORD_MAX) ? COORD_MAX : c;
  endfunction

  // Offer one word after a random gap and hold it until the block takes it.
  task automatic offer_probe(in_word_t w);
    bit taken;
    while ($urandom_range(0, 99) < idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i <= w;
    do begin
      @(negedge clk_i);
      taken = !in_stall_o;
      @(posedge clk_i);
    end while (!taken);
    tracker.take_probe(w);
    words_sent++;
  endtask

  initial begin
    int      rad_top;
    int      run_len;
    int      roll;
    int      pick;
    int      phase;
    circle_t near;

    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed part: empty table, zero radii, touching circles, extremes.
    offer_probe(circle_word(MODE_QUERY, 0, 0, 0));
    offer_probe(circle_word(MODE_APPEND, 0, 0, 0));
    // Two zero radius circles on one center do not overlap.
    offer_probe(circle_word(MODE_APPEND, 0, 0, 0));
    offer_probe(circle_word(MODE_APPEND, COORD_MAX, COORD_MAX, 255));
    offer_probe(circle_word(MODE_QUERY, 1000, 1000, 0));
    // Exactly touching the circle at the origin is not a collision.
    offer_probe(circle_word(MODE_APPEND, 10, 0, 10));
    // A colliding append stores nothing.
    offer_probe(circle_word(MODE_APPEND, 12, 0, 1));
    // Fill the table with points, then try one more.
    for (int i = 0; i < 12; i++) begin
      offer_probe(circle_word(MODE_APPEND, 100 + 40 * i, 400, 0));
    end
    offer_probe(circle_word(MODE_APPEND, 700, 100, 3));
    offer_probe(circle_word(MODE_QUERY, 540, 400, 1));
    offer_probe(circle_word(MODE_SPARE, 540, 401, 2));
    offer_probe(circle_word(MODE_CLEAR, COORD_MAX, COORD_MAX, 255));
    offer_probe(circle_word(MODE_QUERY, 540, 400, 255));

    // Random part: mostly clear-and-fill runs, with some noise words.
    while (words_sent < TOTAL_WORDS) begin
      phase = (words_sent / 120) % 4;
      idle_pct = (phase == 1) ? 57 : (phase == 3) ? 6 : 0;
      stall_pct = (phase == 2) ? 57 : (phase == 3) ? 6 : 0;
      if ($urandom_range(0, 9) < 7) begin
        case ($urandom_range(0, 3))
          0: rad_top = 0;
          1: rad_top = 7;
          2: rad_top = 40;
          default: rad_top = 255;
        endcase
        offer_probe(circle_word(MODE_CLEAR, $urandom, $urandom, $urandom));
        run_len = $urandom_range(4, 26);
        for (int k = 0; k < run_len; k++) begin
          roll = $urandom_range(0, 99);
          if (roll < 70) begin
            offer_probe(circle_word(MODE_APPEND, $urandom, $urandom,
                                    $urandom_range(0, rad_top)));
          end else if (roll < 90 && tracker.placed_count > 0) begin
            // Probe close to a stored circle to reach varied hit indexes.
            pick = $urandom_range(0, tracker.placed_count - 1);
            near = tracker.placed[pick];
            offer_probe(circle_word($urandom_range(0, 1) ? MODE_QUERY : MODE_SPARE,
                                    clamp_coord(int'(near.x) + $urandom_range(0, 6) - 3),
                                    clamp_coord(int'(near.y) + $urandom_range(0, 6) - 3),
                                    $urandom_range(0, 12)));
          end else begin
            offer_probe(circle_word(MODE_QUERY, $urandom, $urandom, $urandom));
          end
        end
      end else begin
        run_len = $urandom_range(1, 10);
        for (int k = 0; k < run_len; k++) begin
          offer_probe(circle_word(MODE_BITS'($urandom_range(0, 3)),
                                  $urandom, $urandom, $urandom));
        end
      end
    end
    in_valid_i <= 1'b0;

    // Let the last results drain, then watch for stray words.
    while (tracker.due_verdicts.size() != 0) begin
      @(posedge clk_i);
    end
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    if (tracker.mismatches == 0 && tracker.due_verdicts.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
